>>> rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion shorthands used by the checker file of this project.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, disabled while reset is asserted (active low).
`define ASSERT_CLK_RST(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("assertion failed");

// Clocked assertion that also holds during reset.
`define ASSERT_CLK(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("assertion failed");

`endif

>>> rtl/mkdlp_pkg.sv
// ----------------------------------------------------------------------------
// mkdlp_pkg
// Types and constants of the multi-key debouncer with long-press timing.
// ----------------------------------------------------------------------------
`default_nettype none

package mkdlp_pkg;

  // Configuration register indexes
  localparam logic [1:0] CFG_KEY_COUNT   = 2'd0;
  localparam logic [1:0] CFG_ACTIVE_LOW  = 2'd1;
  localparam logic [1:0] CFG_DEBOUNCE    = 2'd2;
  localparam logic [1:0] CFG_LONG_PRESS  = 2'd3;

  // Register reset values
  localparam logic [3:0]  KEY_COUNT_RST  = 4'd8;
  localparam logic [7:0]  ACTIVE_LOW_RST = 8'd0;
  localparam logic [7:0]  DEBOUNCE_RST   = 8'd3;
  localparam logic [23:0] LONG_PRESS_RST = 24'd1000;

  localparam logic [23:0] HOLD_MAX = 24'hFF_FFFF;
  localparam logic [7:0]  CNT_MAX  = 8'hFF;

  // Query status codes
  localparam logic STATUS_OK  = 1'b0;
  localparam logic STATUS_BAD = 1'b1;

  typedef struct packed {
    logic [7:0] pin_levels;
    logic [9:0] elapsed_ms;
    logic [2:0] query_key;
  } in_t;

  typedef struct packed {
    logic [7:0]  pressed_mask;
    logic [7:0]  press_edge_mask;
    logic [7:0]  release_edge_mask;
    logic [7:0]  long_press_mask;
    logic [23:0] queried_hold_ms;
    logic        query_status;
  } out_t;

  // Post-tick view of one key lane
  typedef struct packed {
    logic        pressed;
    logic        press_edge;
    logic        release_edge;
    logic        long_flag;
    logic [23:0] hold;
  } lane_res_t;

endpackage

`default_nettype wire

>>> rtl/mkdlp_lane.sv
// ----------------------------------------------------------------------------
// mkdlp_lane
// One key: debounce counter, stable state, hold timer and long-press flag.
// ----------------------------------------------------------------------------
`default_nettype none

module mkdlp_lane (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                upd,
  input  wire logic                raw,
  input  wire logic [9:0]          elapsed_ms,
  input  wire logic [7:0]          need,
  input  wire logic [23:0]         long_press_ms,
  output mkdlp_pkg::lane_res_t     res
);

  logic        stable_r, stable_nxt;
  logic        last_r, last_nxt;
  logic [7:0]  cnt_r, cnt_nxt;
  logic [23:0] hold_r, hold_nxt;
  logic        long_r, long_nxt;

  logic [7:0]  cnt_step;
  logic [23:0] hold_base;
  logic        long_base;
  logic [24:0] hold_sum;
  logic        p_edge, r_edge;

  // Debounce a change of level, then run the hold timer
  always_comb begin
    last_nxt  = raw;
    cnt_nxt   = '0;
    cnt_step  = 8'd1;
    stable_nxt = stable_r;
    hold_base = hold_r;
    long_base = long_r;
    p_edge    = 1'b0;
    r_edge    = 1'b0;
    if (raw != stable_r) begin
      if (raw == last_r) begin
        cnt_step = (cnt_r == mkdlp_pkg::CNT_MAX) ? cnt_r : cnt_r + 8'd1;
      end
      if (cnt_step >= need) begin
        stable_nxt = raw;
        cnt_nxt    = '0;
        hold_base  = '0;
        long_base  = 1'b0;
        p_edge     = raw;
        r_edge     = ~raw;
      end else begin
        cnt_nxt = cnt_step;
      end
    end
    hold_sum = {1'b0, hold_base} + {15'd0, elapsed_ms};
    hold_nxt = hold_base;
    long_nxt = long_base;
    if (stable_nxt) begin
      hold_nxt = hold_sum[24] ? mkdlp_pkg::HOLD_MAX : hold_sum[23:0];
      long_nxt = long_base | (hold_nxt >= long_press_ms);
    end
  end

  assign res.pressed      = stable_nxt;
  assign res.press_edge   = p_edge;
  assign res.release_edge = r_edge;
  assign res.long_flag    = long_nxt;
  assign res.hold         = hold_nxt;

  // Commit the key state on an accepted tick
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stable_r <= 1'b0;
      last_r   <= 1'b0;
      cnt_r    <= '0;
      hold_r   <= '0;
      long_r   <= 1'b0;
    end else if (upd) begin
      stable_r <= stable_nxt;
      last_r   <= last_nxt;
      cnt_r    <= cnt_nxt;
      hold_r   <= hold_nxt;
      long_r   <= long_nxt;
    end
  end

endmodule

`default_nettype wire

>>> rtl/mkdlp_merge.sv
// ----------------------------------------------------------------------------
// mkdlp_merge
// Gathers the lane results into the key masks and answers the hold query.
// ----------------------------------------------------------------------------
`default_nettype none

module mkdlp_merge #(
  parameter int NUM_KEYS = 8
) (
  input  wire mkdlp_pkg::lane_res_t [NUM_KEYS-1:0] lane_res,
  input  wire logic [NUM_KEYS-1:0]                 lane_en,
  input  wire logic [2:0]                          query_key,
  input  wire logic [3:0]                          key_count,
  output mkdlp_pkg::out_t                          result
);

  logic [7:0]  pm, pe, re, lm;
  logic [23:0] q_hold;
  logic        q_ok;

  // Only the first eight lanes reach the masks; idle lanes read zero
  for (genvar g = 0; g < 8; g++) begin : g_mask
    if (g < NUM_KEYS) begin : g_live
      assign pm[g] = lane_en[g] & lane_res[g].pressed;
      assign pe[g] = lane_en[g] & lane_res[g].press_edge;
      assign re[g] = lane_en[g] & lane_res[g].release_edge;
      assign lm[g] = lane_en[g] & lane_res[g].long_flag;
    end else begin : g_none
      assign pm[g] = 1'b0;
      assign pe[g] = 1'b0;
      assign re[g] = 1'b0;
      assign lm[g] = 1'b0;
    end
  end

  // Select the queried lane's hold time
  always_comb begin
    q_hold = '0;
    for (int i = 0; i < NUM_KEYS; i++) begin
      if (i < 8 && query_key == 3'(i)) begin
        q_hold = lane_res[i].hold;
      end
    end
    q_ok = ({1'b0, query_key} < key_count) && (32'(query_key) < 32'(NUM_KEYS));
  end

  always_comb begin
    result.pressed_mask      = pm;
    result.press_edge_mask   = pe;
    result.release_edge_mask = re;
    result.long_press_mask   = lm;
    result.queried_hold_ms   = q_ok ? q_hold : '0;
    result.query_status      = q_ok ? mkdlp_pkg::STATUS_OK : mkdlp_pkg::STATUS_BAD;
  end

endmodule

`default_nettype wire

>>> rtl/multi_key_debounce_long_press.sv
// ----------------------------------------------------------------------------
// multi_key_debounce_long_press
// Debounces up to NUM_KEYS keys, flags press and release edges and long
// presses, and reports one key's hold time per tick.
// ----------------------------------------------------------------------------
// One tick request is taken per clock cycle while in_stall is low. Enabled
// keys update side by side in their own lanes as the tick is accepted, and
// the result goes to the output register, or to the skid register while the
// output waits; this two-entry buffer lets ticks flow while a result waits.
// in_stall rises only when both entries are full. Configuration writes take
// effect on the next tick and should be made while no tick is in flight.
// ----------------------------------------------------------------------------
`default_nettype none

module multi_key_debounce_long_press #(
  parameter int NUM_KEYS = 8
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire mkdlp_pkg::in_t    in_data,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output mkdlp_pkg::out_t        out_data,
  input  wire logic              cfg_we,
  input  wire logic [1:0]        cfg_index,
  input  wire logic [23:0]       cfg_wdata
);

  logic [3:0]  key_count_r;
  logic [7:0]  active_low_r;
  logic [7:0]  debounce_r;
  logic [23:0] long_press_r;

  logic        in_acc;
  logic        out_take;
  logic [7:0]  need;
  logic [NUM_KEYS-1:0] lane_en;
  mkdlp_pkg::lane_res_t [NUM_KEYS-1:0] lane_res;
  mkdlp_pkg::out_t result;

  logic            out_v_r, skid_v_r;
  mkdlp_pkg::out_t out_data_r, skid_data_r;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_count_r  <= mkdlp_pkg::KEY_COUNT_RST;
      active_low_r <= mkdlp_pkg::ACTIVE_LOW_RST;
      debounce_r   <= mkdlp_pkg::DEBOUNCE_RST;
      long_press_r <= mkdlp_pkg::LONG_PRESS_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        mkdlp_pkg::CFG_KEY_COUNT:  key_count_r  <= cfg_wdata[3:0];
        mkdlp_pkg::CFG_ACTIVE_LOW: active_low_r <= cfg_wdata[7:0];
        mkdlp_pkg::CFG_DEBOUNCE:   debounce_r   <= cfg_wdata[7:0];
        mkdlp_pkg::CFG_LONG_PRESS: long_press_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign in_stall = skid_v_r;
  assign in_acc   = in_valid && !in_stall;
  assign out_take = out_v_r && !out_stall;
  // A zero debounce count acts as one
  assign need     = (debounce_r == 8'd0) ? 8'd1 : debounce_r;

  // Key lanes
  for (genvar g = 0; g < NUM_KEYS; g++) begin : g_lane
    logic raw;
    if (g < 8) begin : g_pin
      assign raw = in_data.pin_levels[g] ^ active_low_r[g];
    end else begin : g_nopin
      assign raw = 1'b0;
    end
    assign lane_en[g] = (6'(g) < {2'b00, key_count_r});

    mkdlp_lane u_lane (
      .clk           (clk),
      .rst_n         (rst_n),
      .upd           (in_acc && lane_en[g]),
      .raw           (raw),
      .elapsed_ms    (in_data.elapsed_ms),
      .need          (need),
      .long_press_ms (long_press_r),
      .res           (lane_res[g])
    );
  end

  mkdlp_merge #(.NUM_KEYS(NUM_KEYS)) u_merge (
    .lane_res  (lane_res),
    .lane_en   (lane_en),
    .query_key (in_data.query_key),
    .key_count (key_count_r),
    .result    (result)
  );

  // Output register with skid entry
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else if (skid_v_r) begin
      if (out_take) begin
        skid_v_r <= 1'b0;
      end
    end else if (in_acc) begin
      if (out_v_r && !out_take) begin
        skid_v_r <= 1'b1;
      end else begin
        out_v_r <= 1'b1;
      end
    end else if (out_take) begin
      out_v_r <= 1'b0;
    end
  end

  // Payload moves without reset
  always_ff @(posedge clk) begin
    if (skid_v_r) begin
      if (out_take) begin
        out_data_r <= skid_data_r;
      end
    end else if (in_acc) begin
      if (out_v_r && !out_take) begin
        skid_data_r <= result;
      end else begin
        out_data_r <= result;
      end
    end
  end

  assign out_valid = out_v_r;
  assign out_data  = out_data_r;

endmodule

`default_nettype wire

>>> rtl/mkdlp_checker.sv
// ----------------------------------------------------------------------------
// mkdlp_checker
// Port-level checks of the key debouncer, bound to its top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module mkdlp_checker (
  input wire logic            clk,
  input wire logic            rst_n,
  input wire logic            out_valid,
  input wire logic            out_stall,
  input wire mkdlp_pkg::out_t out_data
);

  logic       out_wait;
  logic [7:0] press_wrong;
  logic [7:0] release_wrong;

  assign out_wait      = out_valid && out_stall;
  assign press_wrong   = out_data.press_edge_mask & ~out_data.pressed_mask;
  assign release_wrong = out_data.release_edge_mask & out_data.pressed_mask;

  // Hold a stalled result
  `ASSERT_CLK_RST(a_out_hold, clk, rst_n, out_wait |=> out_valid && $stable(out_data))

  // A press edge belongs to a pressed key, a release edge to a released key
  `ASSERT_CLK_RST(a_press_edge, clk, rst_n, out_valid |-> press_wrong == 8'd0)
  `ASSERT_CLK_RST(a_release_edge, clk, rst_n, out_valid |-> release_wrong == 8'd0)

  // A rejected query reports no hold time
  `ASSERT_CLK_RST(a_bad_query, clk, rst_n, out_valid && out_data.query_status |-> out_data.queried_hold_ms == 24'd0)

  // Drop every result on reset
  `ASSERT_CLK(a_reset_empty, clk, !rst_n |=> !out_valid)

endmodule

bind multi_key_debounce_long_press mkdlp_checker u_mkdlp_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

`default_nettype wire
